@@ rtl/cfra_pkg.sv @@
// Package: shared constants, codes and controller/datapath interface types.
package cfra_pkg;

    localparam int FRAC_BITS_DEF = 32;
    localparam int INT_BITS_DEF  = 31;

    localparam int VALUE_W = 64;
    localparam int NUM_W   = 32;
    localparam int DEN_W   = 32;
    localparam int ERR_W   = 40;
    localparam int STS_W   = 2;
    localparam int MAXN_W  = 31;
    localparam int MAXD_W  = 32;
    localparam int CFG_W   = 32;

    localparam logic [MAXN_W-1:0] MAXN_RESET = 31'd32767;
    localparam logic [MAXD_W-1:0] MAXD_RESET = 32'd65535;
    localparam logic [30:0]       RECIP_LIMIT = 31'h7FFF_FFFF;
    localparam logic [ERR_W-1:0]  ZERO_ERROR = 40'h64_0000_0000;

    // register indexes
    localparam logic CFG_MAX_NUM = 1'b0;
    localparam logic CFG_MAX_DEN = 1'b1;

    // result status codes
    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_ZERO  = 2'd1;
    localparam logic [STS_W-1:0] STS_RANGE = 2'd2;

    typedef enum logic [1:0] {
        RES_OK,
        RES_ZERO,
        RES_RANGE
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_CHECK,
        S_DIV,
        S_DIVW,
        S_FDIV,
        S_FDIVW,
        S_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic load;
        logic mul;
        logic check;
        logic div_start;
        logic div_long;
        logic div_take;
        logic ratio_take;
        logic emit;
        t_res res;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic zero;
        logic fits;
        logic stop;
        logic any;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/cfra_div.sv @@
// Restoring divider, one quotient bit per cycle, short or long dividend.
module cfra_div #(
    parameter int SHORT_BITS = cfra_pkg::FRAC_BITS_DEF + 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_long,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quot,
    output logic [31:0] o_rem
);

    localparam logic [6:0] LONG_CNT  = 7'd64;
    localparam logic [6:0] SHORT_CNT = 7'(SHORT_BITS);

    logic        r_run, n_run;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_dq, n_dq;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_dsr, n_dsr;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;

    assign rem_sh  = {r_rem, r_dq[63]};
    assign rem_sub = rem_sh - {1'b0, r_dsr};

    always_comb begin
        n_run = r_run;
        n_cnt = r_cnt;
        n_dq  = r_dq;
        n_rem = r_rem;
        n_dsr = r_dsr;
        if (i_start) begin
            n_run = 1'b1;
            n_rem = '0;
            n_dsr = i_divisor;
            if (i_long) begin
                n_cnt = LONG_CNT;
                n_dq  = i_dividend;
            end else begin
                n_cnt = SHORT_CNT;
                n_dq  = i_dividend << (64 - SHORT_BITS);
            end
        end else if (r_run && r_cnt != '0) begin
            n_cnt = r_cnt - 7'd1;
            if (!rem_sub[32]) begin
                n_rem = rem_sub[31:0];
                n_dq  = {r_dq[62:0], 1'b1};
            end else begin
                n_rem = rem_sh[31:0];
                n_dq  = {r_dq[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_run <= n_run;
            r_cnt <= n_cnt;
        end
        r_dq  <= n_dq;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_done = r_run && (r_cnt == '0);
    assign o_quot = r_dq;
    assign o_rem  = r_rem;

endmodule

@@ rtl/cfra_dp.sv @@
// Datapath: config registers, convergent recurrence, divider, output register.
module cfra_dp #(
    parameter int FRAC_BITS = cfra_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS  = cfra_pkg::INT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cfra_pkg::t_cmd             i_cmd,
    output cfra_pkg::t_sts             o_sts,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [cfra_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic [63:0]                i_value,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [31:0]                o_num,
    output logic [31:0]                o_den,
    output logic [39:0]                o_err,
    output logic [1:0]                 o_status
);

    localparam int VALUE_BITS = INT_BITS + FRAC_BITS + 1;
    localparam logic [63:0] VMASK = {64{1'b1}} >> (64 - VALUE_BITS);
    localparam logic [63:0] FMASK = {64{1'b1}} >> (64 - FRAC_BITS);
    localparam logic [32:0] Q_INIT = 33'd1 << FRAC_BITS;

    // configuration
    logic [30:0] r_maxn;
    logic [31:0] r_maxd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maxn <= cfra_pkg::MAXN_RESET;
            r_maxd <= cfra_pkg::MAXD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cfra_pkg::CFG_MAX_NUM: r_maxn <= i_cfg_wdata[30:0];
                cfra_pkg::CFG_MAX_DEN: r_maxd <= i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // working registers
    logic [63:0] r_value, r_mag, r_ratio;
    logic        r_neg, r_any;
    logic [32:0] r_p, r_q;
    logic [31:0] r_a, r_r;
    logic [30:0] r_h0, r_h1;
    logic [31:0] r_k0, r_k1;
    logic [63:0] r_den_prod;
    logic [62:0] r_num_prod;
    logic [62:0] r_lim_prod;

    logic [63:0] v_m, mag_c;
    logic        neg_c;
    logic [63:0] den_c, num_c;
    logic        fits_c, stop_c;

    logic        div_done;
    logic [63:0] div_quot, div_dividend;
    logic [31:0] div_rem, div_divisor;

    assign v_m   = r_value & VMASK;
    assign neg_c = v_m[VALUE_BITS-1];
    assign mag_c = neg_c ? ((~v_m + 64'd1) & VMASK) : v_m;

    assign den_c  = r_den_prod + {32'd0, r_k1};
    assign num_c  = {1'b0, r_num_prod} + {33'd0, r_h1};
    assign fits_c = (den_c <= {32'd0, r_maxd}) && (num_c <= {33'd0, r_maxn});
    assign stop_c = (r_r == '0) || ({31'd0, r_q} > {1'b0, r_lim_prod});

    assign div_dividend = i_cmd.div_long ? {1'b0, r_h0, 32'd0} : {31'd0, r_p};
    assign div_divisor  = i_cmd.div_long ? r_k0 : r_q[31:0];

    cfra_div #(
        .SHORT_BITS(FRAC_BITS + 1)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_long    (i_cmd.div_long),
        .i_dividend(div_dividend),
        .i_divisor (div_divisor),
        .o_done    (div_done),
        .o_quot    (div_quot),
        .o_rem     (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any <= 1'b0;
        end else if (i_cmd.load) begin
            r_any <= 1'b0;
        end else if (i_cmd.check && fits_c) begin
            r_any <= 1'b1;
        end
        if (i_cmd.accept) r_value <= i_value;
        // first term comes straight from the fixed-point split
        if (i_cmd.load) begin
            r_neg <= neg_c;
            r_mag <= mag_c;
            r_a   <= 32'(mag_c >> FRAC_BITS);
            r_r   <= 32'(mag_c & FMASK);
            r_p   <= Q_INIT;
            r_q   <= Q_INIT;
            r_h0  <= 31'd1;
            r_h1  <= '0;
            r_k0  <= '0;
            r_k1  <= 32'd1;
        end
        if (i_cmd.mul) begin
            r_den_prod <= 64'(r_k0) * 64'(r_a);
            r_num_prod <= 63'(r_h0) * 63'(r_a);
            r_lim_prod <= 63'(cfra_pkg::RECIP_LIMIT) * 63'(r_r);
        end
        // accept convergent and shift remainder pair
        if (i_cmd.check && fits_c) begin
            r_h1 <= r_h0;
            r_h0 <= num_c[30:0];
            r_k1 <= r_k0;
            r_k0 <= den_c[31:0];
            r_p  <= r_q;
            r_q  <= {1'b0, r_r};
        end
        if (i_cmd.div_take) begin
            r_a <= div_quot[31:0];
            r_r <= div_rem;
        end
        if (i_cmd.ratio_take) r_ratio <= div_quot;
    end

    // output register
    logic        r_oval;
    logic [31:0] r_onum, r_oden;
    logic [39:0] r_oerr;
    logic [1:0]  r_osts;
    logic [63:0] magq;
    logic [63:0] err_full;

    assign magq     = r_mag << (32 - FRAC_BITS);
    assign err_full = magq - r_ratio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (i_cmd.emit) begin
            r_oval <= 1'b1;
        end else if (i_ready) begin
            r_oval <= 1'b0;
        end
        if (i_cmd.emit) begin
            unique case (i_cmd.res)
                cfra_pkg::RES_ZERO: begin
                    r_onum <= '0;
                    r_oden <= 32'd1;
                    r_oerr <= cfra_pkg::ZERO_ERROR;
                    r_osts <= cfra_pkg::STS_ZERO;
                end
                cfra_pkg::RES_RANGE: begin
                    r_onum <= '0;
                    r_oden <= 32'd1;
                    r_oerr <= '0;
                    r_osts <= cfra_pkg::STS_RANGE;
                end
                default: begin
                    r_onum <= r_neg ? (32'd0 - {1'b0, r_h0}) : {1'b0, r_h0};
                    r_oden <= r_k0;
                    r_oerr <= err_full[39:0];
                    r_osts <= cfra_pkg::STS_OK;
                end
            endcase
        end
    end

    assign o_valid  = r_oval;
    assign o_num    = r_onum;
    assign o_den    = r_oden;
    assign o_err    = r_oerr;
    assign o_status = r_osts;

    assign o_sts.zero     = (mag_c == '0);
    assign o_sts.fits     = fits_c;
    assign o_sts.stop     = stop_c;
    assign o_sts.any      = r_any;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_oval || i_ready;

endmodule

@@ rtl/cfra_ctrl.sv @@
// Controller: sequences load, multiply, check, divide and emit steps.
module cfra_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cfra_pkg::t_sts i_sts,
    output cfra_pkg::t_cmd o_cmd
);

    cfra_pkg::t_state r_state, n_state;
    cfra_pkg::t_res   r_res, n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfra_pkg::S_IDLE;
            r_res   <= cfra_pkg::RES_OK;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        o_cmd   = '0;
        o_cmd.res = r_res;
        o_ready = 1'b0;
        unique case (r_state)
            cfra_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = cfra_pkg::S_LOAD;
                end
            end
            cfra_pkg::S_LOAD: begin
                o_cmd.load = 1'b1;
                if (i_sts.zero) begin
                    n_res   = cfra_pkg::RES_ZERO;
                    n_state = cfra_pkg::S_EMIT;
                end else begin
                    n_state = cfra_pkg::S_MUL;
                end
            end
            cfra_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = cfra_pkg::S_CHECK;
            end
            cfra_pkg::S_CHECK: begin
                o_cmd.check = 1'b1;
                priority if (!i_sts.fits) begin
                    if (i_sts.any) begin
                        n_state = cfra_pkg::S_FDIV;
                    end else begin
                        n_res   = cfra_pkg::RES_RANGE;
                        n_state = cfra_pkg::S_EMIT;
                    end
                end else if (i_sts.stop) begin
                    n_state = cfra_pkg::S_FDIV;
                end else begin
                    n_state = cfra_pkg::S_DIV;
                end
            end
            cfra_pkg::S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state = cfra_pkg::S_DIVW;
            end
            cfra_pkg::S_DIVW: begin
                if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state = cfra_pkg::S_MUL;
                end
            end
            cfra_pkg::S_FDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_long  = 1'b1;
                n_state = cfra_pkg::S_FDIVW;
            end
            cfra_pkg::S_FDIVW: begin
                o_cmd.div_long = 1'b1;
                if (i_sts.div_done) begin
                    o_cmd.ratio_take = 1'b1;
                    n_res   = cfra_pkg::RES_OK;
                    n_state = cfra_pkg::S_EMIT;
                end
            end
            cfra_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = cfra_pkg::S_IDLE;
                end
            end
            default: n_state = cfra_pkg::S_IDLE;
        endcase
    end

endmodule

@@ rtl/continued_fraction_rational_approx_unit.sv @@
// Top level: best rational approximation by continued-fraction convergents.
//
// Channel  | Dir | Signals                         | Transaction
// ---------+-----+---------------------------------+---------------------------------
// in       | in  | s_axis_tvalid/tready/tdata      | one Q31.32 value
// out      | out | m_axis_tvalid/tready/tdata/tuser| num, den, error; status in tuser
// cfg      | in  | i_cfg_we/i_cfg_idx/i_cfg_wdata  | one register write
//
// An item holds the controller from accept to emit: a load step, then per convergent
// check a multiply and a check step; each further term adds a divider start and wait,
// and the final error ratio a long pass of the same divider. Zero input goes from load
// straight to emit, and an input with no fitting convergent emits after its first check.
// One item is worked on at a time.
// Reset is synchronous; it restores the default bounds and empties the output.
// A result waiting on m_axis_tready does not block acceptance of the next value;
// the next result then waits in the emit step until the output register frees.
module continued_fraction_rational_approx_unit #(
    parameter int FRAC_BITS = cfra_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS  = cfra_pkg::INT_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // [63:0] value
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // [31:0] numerator, [63:32] denominator,
                                         // [103:64] approx_error
    output logic [1:0]   m_axis_tuser,   // [1:0] status
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [31:0]  i_cfg_wdata
);

    cfra_pkg::t_cmd cmd;
    cfra_pkg::t_sts sts;
    logic [31:0] num, den;
    logic [39:0] err;

    cfra_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    cfra_dp #(
        .FRAC_BITS(FRAC_BITS),
        .INT_BITS (INT_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_value    (s_axis_tdata),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_num      (num),
        .o_den      (den),
        .o_err      (err),
        .o_status   (m_axis_tuser)
    );

    assign m_axis_tdata = {err, den, num};

endmodule

@@ tb/tb_continued_fraction_rational_approx_unit.sv @@
// Testbench: continued-fraction rational approximation unit, self-checking stream test.
`timescale 1ns / 100ps

module tb_continued_fraction_rational_approx_unit;
    import cfra_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int LONG_HOLD      = 3000;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic [ERR_W-1:0] err;
        logic [STS_W-1:0] sts;
    } t_approx;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_idx = 1'b0;
    logic [31:0]  i_cfg_wdata = '0;

    // predictor copy of the bounds
    logic [MAXN_W-1:0] bound_num = MAXN_RESET;
    logic [MAXD_W-1:0] bound_den = MAXD_RESET;

    logic [63:0] value_q[$];
    t_approx     approx_q[$];

    bit in_fire, out_fire;
    bit sender_burst, receiver_burst;
    int send_gap, recv_gap, hold_cnt;
    bit hold_req;
    int errors;
    int idle_cycles;

    continued_fraction_rational_approx_unit DUT (.*);

    always #2 i_clk = ~i_clk;

    // convergent expansion of |value| under the current bounds
    function automatic t_approx best_fraction(logic [63:0] v);
        t_approx res;
        logic neg;
        logic [63:0] mag, p, q, h0, h1, k0, k1, a, r, dn, nm, ratio, sn;
        bit any;
        neg = v[63];
        mag = neg ? (~v + 64'd1) : v;
        any = 1'b0;
        if (mag == 64'd0) begin
            res = '{num: '0, den: 32'd1, err: ZERO_ERROR, sts: STS_ZERO};
            return res;
        end
        p = mag; q = 64'd1 << 32;
        h0 = 64'd1; h1 = 64'd0; k0 = 64'd0; k1 = 64'd1;
        forever begin
            a  = p / q;
            r  = p - a * q;
            dn = k0 * a + k1;
            if (dn > {32'd0, bound_den}) break;
            nm = h0 * a + h1;
            if (nm > {33'd0, bound_num}) break;
            h1 = h0; h0 = nm;
            k1 = k0; k0 = dn;
            any = 1'b1;
            if (r == 64'd0) break;
            if (q > 64'h7FFF_FFFF * r) break;
            p = q; q = r;
        end
        if (!any) begin
            res = '{num: '0, den: 32'd1, err: '0, sts: STS_RANGE};
            return res;
        end
        ratio = (h0 << 32) / k0;
        sn = neg ? (64'd0 - h0) : h0;
        res.num = sn[31:0];
        res.den = k0[31:0];
        res.err = 40'(mag - ratio);
        res.sts = STS_OK;
        return res;
    endfunction

    // accept monitor, prediction and result check
    always @(posedge i_clk) begin
        t_approx got, exp_r;
        in_fire  = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_fire = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (in_fire)
            approx_q.push_back(best_fraction(s_axis_tdata));
        if (out_fire) begin
            got = '{num: m_axis_tdata[31:0], den: m_axis_tdata[63:32],
                    err: m_axis_tdata[103:64], sts: m_axis_tuser};
            if (approx_q.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
            end else begin
                exp_r = approx_q.pop_front();
                if (got.num !== exp_r.num) begin
                    $error("numerator exp %h got %h", exp_r.num, got.num); errors++;
                end
                if (got.den !== exp_r.den) begin
                    $error("denominator exp %h got %h", exp_r.den, got.den); errors++;
                end
                if (got.err !== exp_r.err) begin
                    $error("approx_error exp %h got %h", exp_r.err, got.err); errors++;
                end
                if (got.sts !== exp_r.sts) begin
                    $error("status exp %h got %h", exp_r.sts, got.sts); errors++;
                end
            end
        end
        // watchdog on stalled traffic
        if (in_fire || out_fire || (value_q.size() == 0 && approx_q.size() == 0
                                    && !s_axis_tvalid))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_fire) begin
            s_axis_tvalid <= 1'b1;
        end else if (send_gap > 0) begin
            send_gap--;
            s_axis_tvalid <= 1'b0;
        end else if (value_q.size() != 0) begin
            s_axis_tdata  <= value_q.pop_front();
            s_axis_tvalid <= 1'b1;
            if ($urandom_range(0, 31) == 0) sender_burst = !sender_burst;
            send_gap = sender_burst ? 0 : $urandom_range(0, 14);
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // receiver, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = LONG_HOLD;
        end
        if (out_fire) begin
            if ($urandom_range(0, 31) == 0) receiver_burst = !receiver_burst;
            recv_gap = receiver_burst ? 0 : $urandom_range(0, 14);
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic write_bound(logic idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MAX_NUM) bound_num = data[30:0];
        else                    bound_den = data;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (value_q.size() != 0 || approx_q.size() != 0 || s_axis_tvalid);
        repeat (10) @(posedge i_clk);
    endtask

    // value shapes: full random, small integer part, ratio of small integers, often no integer part
    function automatic logic [63:0] random_value();
        logic [63:0] v, n, d;
        case ($urandom_range(0, 3))
            0: v = {$urandom, $urandom};
            1: v = {$urandom_range(0, 300), $urandom};
            2: begin
                n = 64'($urandom_range(0, 5000));
                d = 64'($urandom_range(1, 5000));
                v = (n << 32) / d;
            end
            default: v = {$urandom_range(0, 3) == 0 ? $urandom : 32'd0, $urandom};
        endcase
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    task automatic run_random(int count);
        repeat (count) value_q.push_back(random_value());
        wait_drained();
    endtask

    initial begin
        errors = 0;
        send_gap = 0; recv_gap = 0; hold_cnt = 0; hold_req = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed values at reset bounds
        value_q.push_back(64'd0);
        value_q.push_back(64'd1);
        value_q.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        value_q.push_back(64'h8000_0000_0000_0000);
        value_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        value_q.push_back(64'h0000_0005_0000_0000);
        value_q.push_back(64'h0000_0000_8000_0000);
        value_q.push_back(64'h0000_0003_243F_6A89);
        value_q.push_back(-64'h0000_0003_243F_6A89);
        value_q.push_back(64'h0000_0000_5555_5555);
        value_q.push_back(64'h0001_86A0_0000_0000);
        value_q.push_back(64'h0000_7FFF_0000_0000);
        value_q.push_back(64'h0000_8000_0000_0000);
        wait_drained();
        run_random(200);

        // widest bounds, then a long receiver hold-off under load
        write_bound(CFG_MAX_NUM, 32'h7FFF_FFFF);
        write_bound(CFG_MAX_DEN, 32'hFFFF_FFFF);
        value_q.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        value_q.push_back(64'h8000_0000_0000_0000);
        value_q.push_back(64'd1);
        value_q.push_back(64'h0000_0000_5555_5555);
        hold_req = 1'b1;
        run_random(250);

        // tightest bounds
        write_bound(CFG_MAX_NUM, 32'd1);
        write_bound(CFG_MAX_DEN, 32'd1);
        value_q.push_back(64'h0000_0001_0000_0000);
        value_q.push_back(64'h0000_0002_0000_0000);
        run_random(200);

        // zero denominator bound; wide write keeps low numerator bits
        write_bound(CFG_MAX_DEN, 32'd0);
        write_bound(CFG_MAX_NUM, 32'hFFFF_FFFF);
        run_random(100);

        // random bounds
        repeat (4) begin
            write_bound(CFG_MAX_NUM, $urandom_range(0, 3) == 0 ? $urandom
                                                               : $urandom_range(1, 100000));
            write_bound(CFG_MAX_DEN, $urandom_range(0, 3) == 0 ? $urandom
                                                               : $urandom_range(1, 100000));
            run_random(160);
        end

        repeat (100) @(posedge i_clk);
        if (errors == 0 && approx_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
